@@ rtl/huffman_block_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// huffman_block_decoder_top_defines
// Assertion macros shared by the Huffman block decoder modules.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BLOCK_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_BLOCK_DECODER_TOP_DEFINES_SVH

// Checks that an implication holds on every clock edge out of reset.
`define HBD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds on every clock edge out of reset.
`define HBD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

`endif

@@ rtl/hbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants of the Huffman block decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package hbd_pkg;
    localparam int MaxSymbols  = 16;
    localparam int BlockCoeffs = 16;
    localparam int FreqBits    = 8;
    localparam int SymW   = $clog2(MaxSymbols + 1);     // symbol count width
    localparam int NodeW  = $clog2(2 * MaxSymbols);     // tree node index
    localparam int HeapW  = $clog2(MaxSymbols + 1);     // heap position
    localparam int KeyW   = FreqBits + SymW;            // merged frequency
    localparam int CntW   = $clog2(BlockCoeffs + 1);
    localparam int Nodes  = 2 * MaxSymbols;

    // Controller states.
    typedef enum logic [10:0] {
        ST_HEADER = 11'b00000000001,
        ST_COUNT  = 11'b00000000010,
        ST_SYMS   = 11'b00000000100,
        ST_FREQS  = 11'b00000001000,
        ST_PUSH   = 11'b00000010000,
        ST_SIFT   = 11'b00000100000,
        ST_POP    = 11'b00001000000,
        ST_SINK   = 11'b00010000000,
        ST_ZERO   = 11'b00100000000,
        ST_CODE   = 11'b01000000000,
        ST_ERR    = 11'b10000000000
    } state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_STORE_SYM, OP_STORE_FREQ, OP_PUSH_START, OP_SIFT_UP,
        OP_POP_START, OP_SIFT_DOWN, OP_ROOT
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [7:0]      data;
        logic [SymW-1:0] idx;
        logic            pop_second;   // second pop of a merge
    } dp_cmd_t;

    typedef struct packed {
        logic up_done;    // sift-up finished this cycle
        logic down_done;  // sift-down finished this cycle
    } dp_sts_t;
endpackage
`default_nettype wire

@@ rtl/hbd_datapath.sv @@
// ----------------------------------------------------------------------------
// hbd_datapath
// Symbol and frequency tables, the min-heap and the child tables.
// ----------------------------------------------------------------------------
`default_nettype none
`include "huffman_block_decoder_top_defines.svh"
module hbd_datapath
    import hbd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dp_cmd_t          cmd,
    input  wire logic [SymW-1:0]  sym_count,
    input  wire logic [NodeW-1:0] rd_node,    // node whose children the walk reads
    input  wire logic [NodeW-1:0] sym_node,   // node read out as a leaf
    output dp_sts_t               sts,
    output logic [7:0]            sym_out,    // symbol of sym_node as leaf
    output logic [NodeW-1:0]      left_out,
    output logic [NodeW-1:0]      right_out,
    output logic [NodeW-1:0]      root_out
);
    logic [7:0]          sym_mem   [MaxSymbols];
    logic [FreqBits-1:0] freq_mem  [MaxSymbols];
    logic [KeyW-1:0]     hkey      [MaxSymbols+1];
    logic [NodeW-1:0]    hnode     [MaxSymbols+1];
    logic [NodeW-1:0]    lchild    [Nodes];
    logic [NodeW-1:0]    rchild    [Nodes];

    logic [HeapW-1:0] size_reg, size_next;
    logic [HeapW-1:0] pos_reg, pos_next;       // current heap hole
    logic [KeyW-1:0]  mkey_reg, mkey_next;     // key being moved
    logic [NodeW-1:0] mnode_reg, mnode_next;
    logic [KeyW-1:0]  akey_reg;                // first popped key
    logic [NodeW-1:0] anode_reg;
    logic [NodeW-1:0] root_reg;
    logic [NodeW-1:0] merge_reg;               // next internal node

    logic [HeapW-1:0] par, ch, chr, pick;
    logic             up_stop, down_stop, use_r;
    logic [HeapW:0]   ch_w;

    // Heap neighbor addressing.
    always_comb begin
        par  = pos_reg >> 1;
        ch_w = {pos_reg, 1'b0};
        ch   = ch_w[HeapW-1:0];
        chr  = ch + HeapW'(1);
        use_r = ({1'b0, chr} <= {1'b0, size_reg}) && (ch_w < (HeapW+1)'(size_reg))
                && !(hkey[ch] < hkey[chr]);
        pick = use_r ? chr : ch;
        up_stop   = (pos_reg == HeapW'(1)) || !(mkey_reg < hkey[par]);
        down_stop = (ch_w > (HeapW+1)'(size_reg)) || (mkey_reg <= hkey[pick]);
    end

    always_comb begin
        size_next  = size_reg;
        pos_next   = pos_reg;
        mkey_next  = mkey_reg;
        mnode_next = mnode_reg;
        sts        = '0;
        case (cmd.op)
            OP_PUSH_START: begin
                // A leaf push loads its frequency; after a merge the summed key goes in.
                size_next = size_reg + HeapW'(1);
                pos_next  = size_reg + HeapW'(1);
                if (cmd.pop_second) begin
                    mkey_next  = akey_reg + hkey[0];
                    mnode_next = merge_reg;
                end else begin
                    mkey_next  = KeyW'(freq_mem[cmd.idx[SymW-2:0]]);
                    mnode_next = NodeW'(cmd.idx);
                end
            end
            OP_SIFT_UP: begin
                if (up_stop) sts.up_done = 1'b1;
                else pos_next = par;
            end
            OP_POP_START: begin
                size_next  = size_reg - HeapW'(1);
                pos_next   = HeapW'(1);
                mkey_next  = hkey[size_reg];
                mnode_next = hnode[size_reg];
            end
            OP_SIFT_DOWN: begin
                if (down_stop) sts.down_done = 1'b1;
                else pos_next = pick;
            end
            // Taking the root pops the last entry and empties the heap.
            OP_ROOT: size_next = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= '0;
            root_reg  <= '0;
            merge_reg <= '0;
        end else begin
            size_reg <= size_next;
            if (cmd.op == OP_STORE_FREQ) merge_reg <= NodeW'(sym_count);
            if (cmd.op == OP_ROOT) root_reg <= hnode[1];
            if (cmd.op == OP_PUSH_START && cmd.pop_second)
                merge_reg <= merge_reg + NodeW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        mkey_reg  <= mkey_next;
        mnode_reg <= mnode_next;
        case (cmd.op)
            OP_STORE_SYM:  sym_mem[cmd.idx[SymW-2:0]] <= cmd.data;
            OP_STORE_FREQ: freq_mem[cmd.idx[SymW-2:0]] <= cmd.data[FreqBits-1:0];
            OP_POP_START: begin
                // Slot 0 keeps the popped key; the first pop's node is saved too.
                hkey[0] <= hkey[1];
                if (!cmd.pop_second) begin
                    akey_reg  <= hkey[1];
                    anode_reg <= hnode[1];
                end else begin
                    lchild[merge_reg] <= anode_reg;
                    rchild[merge_reg] <= hnode[1];
                end
            end
            OP_SIFT_UP: begin
                if (up_stop) begin
                    hkey[pos_reg]  <= mkey_reg;
                    hnode[pos_reg] <= mnode_reg;
                end else begin
                    hkey[pos_reg]  <= hkey[par];
                    hnode[pos_reg] <= hnode[par];
                end
            end
            OP_SIFT_DOWN: begin
                if (down_stop) begin
                    hkey[pos_reg]  <= mkey_reg;
                    hnode[pos_reg] <= mnode_reg;
                end else begin
                    hkey[pos_reg]  <= hkey[pick];
                    hnode[pos_reg] <= hnode[pick];
                end
            end
            default: ;
        endcase
    end

    assign sym_out   = (sym_node < NodeW'(MaxSymbols)) ? sym_mem[sym_node[SymW-2:0]] : 8'd0;
    assign left_out  = lchild[rd_node];
    assign right_out = rchild[rd_node];
    assign root_out  = root_reg;

    `HBD_ASSERT_ALWAYS(a_size_bound, aclk, aresetn, size_reg <= HeapW'(MaxSymbols), "heap overflow")
    `HBD_ASSERT_IMP(a_up_pos, aclk, aresetn, cmd.op == OP_SIFT_UP, pos_reg != '0, "sift-up at slot 0")
    `HBD_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, cmd.op == OP_POP_START, size_reg != '0, "pop from empty heap")
endmodule
`default_nettype wire

@@ rtl/hbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbd_ctrl
// Controller: parses the byte stream, sequences tree building, walks codes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "huffman_block_decoder_top_defines.svh"
module hbd_ctrl
    import hbd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       in_byte,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            o_coef,
    output logic [3:0]            o_idx,
    output logic [1:0]            o_mode,
    output logic                  o_last,
    output logic                  o_err,
    output dp_cmd_t               cmd,
    output logic [SymW-1:0]       sym_count,
    output logic [NodeW-1:0]      rd_node,
    output logic [NodeW-1:0]      sym_node,
    input  wire dp_sts_t          sts,
    input  wire logic [7:0]       sym_in,
    input  wire logic [NodeW-1:0] left_in,
    input  wire logic [NodeW-1:0] right_in,
    input  wire logic [NodeW-1:0] root_in
);
    state_t state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [SymW-1:0]  cnt_reg, cnt_next;
    logic [SymW-1:0]  idx_reg, idx_next;      // load index / merge counter
    logic             second_reg, second_next;
    logic [CntW-1:0]  out_reg, out_next;
    logic [NodeW-1:0] walk_reg, walk_next;
    logic             fresh_reg, fresh_next;  // walk must start at the new root
    logic [7:0]       code_reg, code_next;
    logic [3:0]       bit_reg, bit_next;      // bits left in code byte
    logic             ov_reg, ov_next;        // output register full
    logic [7:0]       oc_reg, oc_next;
    logic [3:0]       oi_reg, oi_next;
    logic             ol_reg, ol_next, oe_reg, oe_next;

    logic take, space, single, cb, leaf;
    logic [NodeW-1:0] nxt;

    assign space  = !ov_reg || m_tready;
    assign take   = s_tvalid && s_tready;
    assign single = (cnt_reg <= SymW'(1)) || (root_in < NodeW'(cnt_reg));
    assign cb     = code_reg[7];
    assign nxt    = cb ? left_in : right_in;
    assign leaf   = single || (nxt < NodeW'(cnt_reg));
    // Children come from the saved walk node; the symbol from the node reached.
    assign rd_node  = walk_reg;
    assign sym_node = single ? root_in : nxt;
    assign sym_count = cnt_reg;

    always_comb begin
        unique case (state_reg)
            ST_HEADER, ST_COUNT, ST_SYMS, ST_FREQS: s_tready = 1'b1;
            ST_CODE:  s_tready = (bit_reg == 4'd0);
            ST_ERR, ST_ZERO: s_tready = 1'b0;
            default:  s_tready = 1'b0;
        endcase
        if (state_reg == ST_HEADER || state_reg == ST_COUNT) s_tready = space;
    end

    always_comb begin
        state_next = state_reg; mode_next = mode_reg; cnt_next = cnt_reg;
        idx_next = idx_reg; second_next = second_reg; out_next = out_reg;
        walk_next = walk_reg; fresh_next = fresh_reg;
        code_next = code_reg; bit_next = bit_reg;
        ov_next = ov_reg && !m_tready;
        oc_next = oc_reg; oi_next = oi_reg; ol_next = ol_reg; oe_next = oe_reg;
        cmd = '0;
        cmd.data = in_byte;
        cmd.idx = idx_reg;
        cmd.pop_second = second_reg;
        unique case (state_reg)
            ST_HEADER: if (take) begin
                unique case (in_byte)
                    8'd48, 8'd12, 8'd3, 8'd0: begin
                        mode_next = (in_byte == 8'd48) ? 2'd0 : (in_byte == 8'd12) ? 2'd1
                                  : (in_byte == 8'd3) ? 2'd2 : 2'd3;
                        out_next = '0;
                        state_next = ST_ZERO;
                    end
                    8'd240, 8'd204, 8'd195, 8'd192: begin
                        mode_next = (in_byte == 8'd240) ? 2'd0 : (in_byte == 8'd204) ? 2'd1
                                  : (in_byte == 8'd195) ? 2'd2 : 2'd3;
                        state_next = ST_COUNT;
                    end
                    default: begin
                        ov_next = 1'b1; oc_next = '0; oi_next = '0; ol_next = 1'b0;
                        oe_next = 1'b1; mode_next = 2'd0;
                    end
                endcase
            end
            ST_COUNT: if (take) begin
                if (in_byte == 8'd0 || in_byte > 8'(MaxSymbols)) begin
                    ov_next = 1'b1; oc_next = '0; oi_next = '0; ol_next = 1'b0;
                    oe_next = 1'b1;
                    state_next = ST_HEADER;
                end else begin
                    cnt_next = SymW'(in_byte);
                    idx_next = '0;
                    state_next = ST_SYMS;
                end
            end
            ST_SYMS: if (take) begin
                cmd.op = OP_STORE_SYM;
                idx_next = idx_reg + SymW'(1);
                if (idx_next >= cnt_reg) begin
                    idx_next = '0; state_next = ST_FREQS;
                end
            end
            ST_FREQS: if (take) begin
                cmd.op = OP_STORE_FREQ;
                idx_next = idx_reg + SymW'(1);
                if (idx_next >= cnt_reg) begin
                    idx_next = '0; second_next = 1'b0; state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.op = OP_PUSH_START;
                state_next = ST_SIFT;
            end
            ST_SIFT: begin
                cmd.op = OP_SIFT_UP;
                if (sts.up_done) begin
                    if (!second_reg && idx_reg + SymW'(1) < cnt_reg) begin
                        idx_next = idx_reg + SymW'(1); state_next = ST_PUSH;
                    end else begin
                        // Leaves done (or a merge done): count merges in idx.
                        if (!second_reg) idx_next = SymW'(1);
                        else idx_next = idx_reg + SymW'(1);
                        second_next = 1'b0;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (idx_reg >= cnt_reg) begin
                    cmd.op = OP_ROOT;
                    out_next = '0; bit_next = '0; fresh_next = 1'b1;
                    state_next = ST_CODE;
                end else begin
                    cmd.op = OP_POP_START;
                    state_next = ST_SINK;
                end
            end
            ST_SINK: begin
                cmd.op = OP_SIFT_DOWN;
                if (sts.down_done) begin
                    if (!second_reg) begin
                        second_next = 1'b1; state_next = ST_POP;
                        if (idx_reg >= cnt_reg) state_next = ST_POP;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_ZERO: if (space) begin
                ov_next = 1'b1; oc_next = '0; oi_next = out_reg[3:0]; oe_next = 1'b0;
                ol_next = (out_reg == CntW'(BlockCoeffs - 1));
                out_next = out_reg + CntW'(1);
                if (ol_next) state_next = ST_HEADER;
            end
            ST_CODE: begin
                if (bit_reg == 4'd0) begin
                    // The walk carries over between code bytes of one block.
                    if (fresh_reg) begin
                        walk_next = root_in; fresh_next = 1'b0;
                    end
                    if (take) begin
                        code_next = in_byte; bit_next = 4'd8;
                    end
                end else if (space) begin
                    code_next = {code_reg[6:0], 1'b0};
                    bit_next = bit_reg - 4'd1;
                    if (!single) walk_next = leaf ? root_in : nxt;
                    if (leaf) begin
                        ov_next = 1'b1; oc_next = sym_in; oi_next = out_reg[3:0];
                        oe_next = 1'b0;
                        ol_next = (out_reg == CntW'(BlockCoeffs - 1));
                        out_next = out_reg + CntW'(1);
                        if (ol_next) begin
                            bit_next = '0; state_next = ST_HEADER;
                        end
                    end
                end
            end
            ST_ERR: state_next = ST_HEADER;
            default: state_next = ST_HEADER;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HEADER; mode_reg <= '0; cnt_reg <= '0; idx_reg <= '0;
            second_reg <= 1'b0; out_reg <= '0; walk_reg <= '0; bit_reg <= '0;
            ov_reg <= 1'b0; fresh_reg <= 1'b0;
        end else begin
            state_reg <= state_next; mode_reg <= mode_next; cnt_reg <= cnt_next;
            idx_reg <= idx_next; second_reg <= second_next; out_reg <= out_next;
            walk_reg <= walk_next; bit_reg <= bit_next; ov_reg <= ov_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
        oc_reg <= oc_next; oi_reg <= oi_next; ol_reg <= ol_next; oe_reg <= oe_next;
    end

    assign m_tvalid = ov_reg;
    assign o_coef = oc_reg;
    assign o_idx  = oi_reg;
    assign o_mode = oe_reg && state_reg == ST_HEADER && mode_reg == 2'd0 ? 2'd0 : mode_reg;
    assign o_last = ol_reg;
    assign o_err  = oe_reg;

    `HBD_ASSERT_IMP(a_onehot, aclk, aresetn, 1'b1, $onehot(state_reg), "state not one-hot")
    `HBD_ASSERT_IMP(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 m_tvalid, "output dropped")
    `HBD_ASSERT_IMP(a_last_idx, aclk, aresetn, m_tvalid && o_last, o_idx == 4'(BlockCoeffs - 1), "last off index")
endmodule
`default_nettype wire

@@ rtl/huffman_block_decoder_top.sv @@
// ----------------------------------------------------------------------------
// huffman_block_decoder_top
// Huffman decoder for 4x4 coefficient blocks built from a frequency table.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata fields (low bit up)                | tuser / tlast
// s_      | in  | in_byte[7:0]                             | -
// m_      | out | coefficient[7:0], coeff_index[11:8],     | header_error / last
//         |     | pred_mode[13:12]                         |
// Load bytes are stored as they are taken. A code byte is loaded, then its
// bits are walked one at a time while m_ has space, until the block is full.
// Tree building: n leaf pushes that sift up, n-1 merges of two pops that
// sift down and a push, and then taking the root. aresetn is synchronous.
// Zero blocks emit one coefficient per cycle unless m_ stalls.
// Output stalls hold the controller; one result register sits on m_.
// ----------------------------------------------------------------------------
`default_nettype none
module huffman_block_decoder_top
    import hbd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // coefficient, coeff_index, pred_mode
    output logic             m_tuser,   // header_error
    output logic             m_tlast    // last
);
    dp_cmd_t          cmd;
    dp_sts_t          sts;
    logic [SymW-1:0]  sym_count;
    logic [NodeW-1:0] rd_node, sym_node, left_n, right_n, root_n;
    logic [7:0]       sym, coef;
    logic [3:0]       idx;
    logic [1:0]       mode;

    hbd_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .in_byte(s_tdata),
        .m_tvalid, .m_tready, .o_coef(coef), .o_idx(idx), .o_mode(mode),
        .o_last(m_tlast), .o_err(m_tuser), .cmd, .sym_count, .rd_node, .sym_node,
        .sts, .sym_in(sym), .left_in(left_n), .right_in(right_n), .root_in(root_n)
    );

    hbd_datapath u_dp (
        .aclk, .aresetn, .cmd, .sym_count, .rd_node, .sym_node, .sts, .sym_out(sym),
        .left_out(left_n), .right_out(right_n), .root_out(root_n)
    );

    assign m_tdata = {2'b00, mode, idx, coef};
endmodule
`default_nettype wire

@@ tb/huffman_block_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// huffman_block_decoder_top_test
// Streams zero blocks, coded blocks and bad headers into the Huffman block
// decoder and checks every coefficient against a software decoder.
// ----------------------------------------------------------------------------
`default_nettype none

// Expected coefficient fields, as they appear on the m_ channel.
typedef struct packed {
    logic [7:0] coefficient;
    logic [3:0] coeff_index;
    logic [1:0] pred_mode;
    logic       last;
    logic       header_error;
} coeff_rec_t;

// Decoder model and queue of coefficients still due from the block.
class coeff_scoreboard;
    localparam int PhHeader = 0, PhCount = 1, PhSyms = 2, PhFreqs = 3, PhCode = 4;
    localparam logic [7:0] ZeroHdr[4]  = '{8'd48, 8'd12, 8'd3, 8'd0};
    localparam logic [7:0] CodedHdr[4] = '{8'd240, 8'd204, 8'd195, 8'd192};

    int         phase;
    logic [1:0] mode;
    int         sym_total, load_pos, walk, root, coeffs_out;
    logic [7:0] sym_tab[hbd_pkg::MaxSymbols];
    int         freq_tab[hbd_pkg::MaxSymbols];
    int         hkey[hbd_pkg::MaxSymbols + 1];
    int         hnode[hbd_pkg::MaxSymbols + 1];
    int         hsize;
    int         lchild[hbd_pkg::Nodes], rchild[hbd_pkg::Nodes];
    coeff_rec_t due[$];
    int         errors, checked;

    function new();
        phase = PhHeader;
        mode = 0;
        sym_total = 0; load_pos = 0; walk = 0; root = 0; coeffs_out = 0;
        hsize = 0; errors = 0; checked = 0;
    endfunction

    // True while code bytes are still due for the current block.
    function bit in_code();
        return phase == PhCode;
    endfunction

    function void heap_insert(int key, int node);
        int i;
        hsize++;
        i = hsize;
        while (i != 1 && key < hkey[i / 2]) begin
            hkey[i] = hkey[i / 2];
            hnode[i] = hnode[i / 2];
            i = i / 2;
        end
        hkey[i] = key;
        hnode[i] = node;
    endfunction

    function int heap_take(output int key);
        int top, par, ch, tk, tn;
        top = hnode[1];
        key = hkey[1];
        tk = hkey[hsize];
        tn = hnode[hsize];
        hsize--;
        par = 1;
        ch = 2;
        while (ch <= hsize) begin
            if (ch + 1 <= hsize && !(hkey[ch] < hkey[ch + 1])) ch++;
            if (tk <= hkey[ch]) break;
            hkey[par] = hkey[ch];
            hnode[par] = hnode[ch];
            par = ch;
            ch = par * 2;
        end
        hkey[par] = tk;
        hnode[par] = tn;
        return top;
    endfunction

    function void grow_tree();
        int a, b, ka, kb;
        hsize = 0;
        for (int i = 0; i < sym_total; i++) heap_insert(freq_tab[i], i);
        for (int i = 1; i < sym_total; i++) begin
            a = heap_take(ka);
            b = heap_take(kb);
            lchild[sym_total + i - 1] = a;
            rchild[sym_total + i - 1] = b;
            heap_insert(ka + kb, sym_total + i - 1);
        end
        root = heap_take(ka);
        walk = root;
    endfunction

    function void push_coeff(logic [7:0] c, int idx, logic [1:0] m, logic lst,
                             logic err);
        coeff_rec_t r;
        r.coefficient = c;
        r.coeff_index = idx[3:0];
        r.pred_mode = m;
        r.last = lst;
        r.header_error = err;
        due.push_back(r);
    endfunction

    function void emit_leaf(int leaf);
        push_coeff(sym_tab[leaf], coeffs_out, mode,
                   coeffs_out == hbd_pkg::BlockCoeffs - 1, 1'b0);
        coeffs_out++;
    endfunction

    // Notes one accepted input byte and queues the coefficients it causes.
    function void note_byte(logic [7:0] b);
        logic hit;
        hit = 1'b0;
        case (phase)
            PhHeader: begin
                for (int m = 0; m < 4; m++) begin
                    if (b == ZeroHdr[m]) begin
                        mode = 2'(m);
                        hit = 1'b1;
                        for (int i = 0; i < hbd_pkg::BlockCoeffs; i++)
                            push_coeff(8'd0, i, mode, i == hbd_pkg::BlockCoeffs - 1,
                                       1'b0);
                    end else if (b == CodedHdr[m]) begin
                        mode = 2'(m);
                        hit = 1'b1;
                        phase = PhCount;
                    end
                end
                if (!hit) push_coeff(8'd0, 0, 2'd0, 1'b0, 1'b1);
            end
            PhCount: begin
                if (b == 0 || b > hbd_pkg::MaxSymbols) begin
                    push_coeff(8'd0, 0, mode, 1'b0, 1'b1);
                    phase = PhHeader;
                end else begin
                    sym_total = b;
                    load_pos = 0;
                    phase = PhSyms;
                end
            end
            PhSyms: begin
                sym_tab[load_pos] = b;
                load_pos++;
                if (load_pos >= sym_total) begin
                    load_pos = 0;
                    phase = PhFreqs;
                end
            end
            PhFreqs: begin
                freq_tab[load_pos] = b;
                load_pos++;
                if (load_pos >= sym_total) begin
                    grow_tree();
                    coeffs_out = 0;
                    phase = PhCode;
                end
            end
            default: begin
                for (int i = 0; i < 8 && coeffs_out < hbd_pkg::BlockCoeffs; i++) begin
                    if (sym_total <= 1 || root < sym_total) begin
                        emit_leaf(root);
                        continue;
                    end
                    walk = b[7 - i] ? lchild[walk] : rchild[walk];
                    if (walk < sym_total) begin
                        emit_leaf(walk);
                        walk = root;
                    end
                end
                if (coeffs_out >= hbd_pkg::BlockCoeffs) phase = PhHeader;
            end
        endcase
    endfunction

    // Compares one result transaction with the oldest expected coefficient.
    function void check_coeff(logic [15:0] data, logic user, logic tlast);
        coeff_rec_t e;
        checked++;
        if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result data=%h err=%b last=%b", $time, data,
                     user, tlast);
            return;
        end
        e = due.pop_front();
        if (data[7:0] !== e.coefficient || data[11:8] !== e.coeff_index ||
            data[13:12] !== e.pred_mode || data[15:14] !== 2'b00 ||
            tlast !== e.last || user !== e.header_error) begin
            errors++;
            $display("%0t: expected coef=%h idx=%0d mode=%0d last=%b err=%b",
                     $time, e.coefficient, e.coeff_index, e.pred_mode, e.last,
                     e.header_error);
            $display("%0t: actual   coef=%h idx=%0d mode=%0d last=%b err=%b",
                     $time, data[7:0], data[11:8], data[13:12], tlast, user);
        end
    endfunction
endclass

module huffman_block_decoder_top_test;
    import hbd_pkg::*;

    localparam int StallLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    coeff_scoreboard board = new();
    logic [7:0]      byte_q[$];
    int              quiet_cycles = 0;
    int              bytes_sent = 0;
    int              blocks_coded = 0;
    logic            no_gaps = 1'b0;

    huffman_block_decoder_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: random back-pressure, checking on every transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_coeff(m_tdata, m_tuser, m_tlast);
            m_tready <= no_gaps || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         board.due.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Sends one byte, with an optional random gap before it.
    task automatic send_byte(logic [7:0] b);
        if (!no_gaps) begin
            while ($urandom_range(99) < 16) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic flush_queue();
        while (byte_q.size() > 0) send_byte(byte_q.pop_front());
    endtask

    // Queues a coded block; code bytes are added until the model says it is full.
    task automatic coded_block(int m, int n, logic [7:0] syms[], logic [7:0] freqs[],
                               int code_style);
        logic [7:0] hdr[4];
        logic [7:0] cb;
        hdr = '{8'd240, 8'd204, 8'd195, 8'd192};
        byte_q.push_back(hdr[m]);
        byte_q.push_back(n[7:0]);
        for (int i = 0; i < n; i++) byte_q.push_back(syms[i]);
        for (int i = 0; i < n; i++) byte_q.push_back(freqs[i]);
        flush_queue();
        blocks_coded++;
        while (board.in_code()) begin
            case (code_style)
                0: cb = 8'hFF;
                1: cb = 8'h00;
                default: cb = 8'($urandom_range(255));
            endcase
            send_byte(cb);
        end
    endtask

    task automatic random_coded_block(int max_n);
        logic [7:0] syms[], freqs[];
        int n;
        n = ($urandom_range(9) == 0) ? max_n : $urandom_range(max_n, 1);
        syms = new[n];
        freqs = new[n];
        foreach (syms[i]) begin
            syms[i] = 8'($urandom_range(255));
            freqs[i] = ($urandom_range(3) == 0) ? 8'd7 : 8'($urandom_range(255));
        end
        coded_block($urandom_range(3), n, syms, freqs, 2);
    endtask

    initial begin
        logic [7:0] syms[], freqs[];
        logic [7:0] noise;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero blocks in every mode, bad headers and bad counts.
        byte_q = '{8'd48, 8'd12, 8'd3, 8'd0, 8'd1, 8'd255,
                   8'd240, 8'd0, 8'd204, 8'd17, 8'd195, 8'd255};
        flush_queue();

        // Single symbol, equal-frequency ties, and a full 16-symbol table.
        syms = '{8'h80};
        freqs = '{8'd0};
        coded_block(3, 1, syms, freqs, 1);
        syms = '{8'h7F, 8'h01, 8'hFF};
        freqs = '{8'd5, 8'd5, 8'd5};
        coded_block(0, 3, syms, freqs, 0);
        syms = new[16];
        freqs = new[16];
        foreach (syms[i]) begin
            syms[i] = 8'(i * 17);
            freqs[i] = (i % 2) ? 8'd255 : 8'd1;
        end
        coded_block(2, 16, syms, freqs, 2);

        // Random: mostly well-formed coded blocks, some zero blocks, bad counts and noise.
        while (bytes_sent < 160) begin
            if (bytes_sent > 60 && bytes_sent < 110) no_gaps = 1'b1;
            else no_gaps = 1'b0;
            case ($urandom_range(9))
                0: send_byte(8'd0 | ({$urandom_range(3)} == 0 ? 8'd48 : 8'd12));
                1: begin
                    noise = 8'($urandom_range(255));
                    send_byte(noise);
                end
                2: begin
                    send_byte(8'd240);
                    send_byte(($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255, 17)));
                end
                default: random_coded_block(($urandom_range(4) == 0) ? 16 : 5);
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        while (board.due.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Sent %0d bytes, %0d coded blocks, checked %0d results.",
                 bytes_sent, blocks_coded, board.checked);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire
